// ===== sv/wake_cone_cell_classifier_assert.svh =====
// assertion helpers for the wake cone cell classifier
`ifndef WAKE_CONE_CELL_CLASSIFIER_ASSERT_SVH
`define WAKE_CONE_CELL_CLASSIFIER_ASSERT_SVH

// same-cycle implication
`define WCC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define WCC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/wcc_pkg.sv =====
`timescale 1ns / 1ps

package wcc_pkg;

  localparam int CoordW = 32;
  localparam int DiffW  = CoordW + 1;
  localparam int AxisW  = 18;
  localparam int LenW   = 31;
  localparam int TanW   = 24;
  localparam int IdxW   = 24;
  localparam int FracW  = 16;
  localparam int ProdW  = DiffW + AxisW;
  localparam int DotW   = ProdW + 2;
  localparam int QW     = LenW;
  localparam int QaW    = QW + 1 + AxisW;
  localparam int PerpW  = DiffW + FracW + 2;
  localparam int MagW   = PerpW - 1;
  localparam int RadW   = QW + TanW;
  localparam int HalfW  = 28;
  localparam int SqInW  = 2 * HalfW;
  localparam int SqW    = 2 * SqInW;
  localparam int DistW  = SqW + 2;
  localparam int CfgW   = 32;
  localparam int CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ORIGIN_X    = 3'd0,
    REG_ORIGIN_Y    = 3'd1,
    REG_ORIGIN_Z    = 3'd2,
    REG_AXIS_X      = 3'd3,
    REG_AXIS_Y      = 3'd4,
    REG_AXIS_Z      = 3'd5,
    REG_CONE_LENGTH = 3'd6,
    REG_TAN_HALF    = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic            valid;
    logic [IdxW-1:0] index;
    logic            inrange;
  } tag_t;

  typedef struct packed {
    tag_t                       tag;
    logic [2:0][DiffW-1:0]      d;
    logic [QW-1:0]              q;
  } axial_t;

  typedef struct packed {
    tag_t                       tag;
    logic [2:0][MagW-1:0]       mag;
    logic [RadW-1:0]            rad;
  } radial_t;

endpackage

// ===== sv/wcc_axial.sv =====
`timescale 1ns / 1ps

module wcc_axial (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   en,
  input  logic                                   in_valid,
  input  logic [wcc_pkg::IdxW-1:0]               in_index,
  input  logic [2:0][wcc_pkg::CoordW-1:0]        center,
  input  logic [2:0][wcc_pkg::CoordW-1:0]        origin,
  input  logic [2:0][wcc_pkg::AxisW-1:0]         axis,
  input  logic [wcc_pkg::LenW-1:0]               len,
  output wcc_pkg::axial_t                        axial
);

  // stage 1: offset from apex
  logic                              v1_r;
  logic [wcc_pkg::IdxW-1:0]          idx1_r;
  logic signed [wcc_pkg::DiffW-1:0]  d1_r [3];
  logic signed [wcc_pkg::DiffW-1:0]  d1_nxt [3];

  // stage 2: per-axis products
  logic                              v2_r;
  logic [wcc_pkg::IdxW-1:0]          idx2_r;
  logic signed [wcc_pkg::DiffW-1:0]  d2_r [3];
  logic signed [wcc_pkg::ProdW-1:0]  prod_r [3];
  logic signed [wcc_pkg::ProdW-1:0]  prod_nxt [3];

  // stage 3: axial distance
  logic                              v3_r;
  logic [wcc_pkg::IdxW-1:0]          idx3_r;
  logic signed [wcc_pkg::DiffW-1:0]  d3_r [3];
  logic signed [wcc_pkg::DotW-1:0]   p_r;
  logic signed [wcc_pkg::DotW-1:0]   p_nxt;

  // stage 4: range test and floor
  wcc_pkg::axial_t                   axial_r;
  wcc_pkg::axial_t                   axial_nxt;
  logic signed [wcc_pkg::DotW-1:0]   limit;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d1_nxt[i] = $signed({center[i][wcc_pkg::CoordW-1], center[i]})
                - $signed({origin[i][wcc_pkg::CoordW-1], origin[i]});
      prod_nxt[i] = d1_r[i] * $signed(axis[i]);
    end
    p_nxt = $signed({{(wcc_pkg::DotW-wcc_pkg::ProdW){prod_r[0][wcc_pkg::ProdW-1]}}, prod_r[0]})
          + $signed({{(wcc_pkg::DotW-wcc_pkg::ProdW){prod_r[1][wcc_pkg::ProdW-1]}}, prod_r[1]})
          + $signed({{(wcc_pkg::DotW-wcc_pkg::ProdW){prod_r[2][wcc_pkg::ProdW-1]}}, prod_r[2]});
    limit = $signed({{(wcc_pkg::DotW-wcc_pkg::LenW-wcc_pkg::FracW){1'b0}}, len,
                     {wcc_pkg::FracW{1'b0}}});
    axial_nxt.tag.valid   = v3_r;
    axial_nxt.tag.index   = idx3_r;
    axial_nxt.tag.inrange = (p_r > 0) && (p_r <= limit);
    for (int i = 0; i < 3; i++) begin
      axial_nxt.d[i] = d3_r[i];
    end
    axial_nxt.q = p_r[wcc_pkg::QW+wcc_pkg::FracW-1:wcc_pkg::FracW];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      axial_r.tag.valid <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      axial_r.tag.valid <= axial_nxt.tag.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idx1_r <= in_index;
      idx2_r <= idx1_r;
      idx3_r <= idx2_r;
      for (int i = 0; i < 3; i++) begin
        d1_r[i]   <= d1_nxt[i];
        d2_r[i]   <= d1_r[i];
        d3_r[i]   <= d2_r[i];
        prod_r[i] <= prod_nxt[i];
      end
      p_r <= p_nxt;
      axial_r.tag.index   <= axial_nxt.tag.index;
      axial_r.tag.inrange <= axial_nxt.tag.inrange;
      axial_r.d           <= axial_nxt.d;
      axial_r.q           <= axial_nxt.q;
    end
  end

  assign axial = axial_r;

endmodule

// ===== sv/wcc_radial.sv =====
`timescale 1ns / 1ps

module wcc_radial (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  wcc_pkg::axial_t                 axial,
  input  logic [2:0][wcc_pkg::AxisW-1:0]  axis,
  input  logic [wcc_pkg::TanW-1:0]        tan_half,
  output wcc_pkg::radial_t                radial
);

  // stage 1: projection back onto axis, cone radius
  wcc_pkg::tag_t                     tag1_r;
  logic signed [wcc_pkg::DiffW-1:0]  d1_r [3];
  logic signed [wcc_pkg::QaW-1:0]    qa_r [3];
  logic signed [wcc_pkg::QaW-1:0]    qa_nxt [3];
  logic [wcc_pkg::RadW-1:0]          rad1_r;
  logic [wcc_pkg::RadW-1:0]          rad1_nxt;

  // stage 2: perpendicular offset
  wcc_pkg::tag_t                     tag2_r;
  logic signed [wcc_pkg::PerpW-1:0]  perp_r [3];
  logic signed [wcc_pkg::PerpW-1:0]  perp_nxt [3];
  logic [wcc_pkg::RadW-1:0]          rad2_r;

  // stage 3: magnitudes
  wcc_pkg::radial_t                  radial_r;
  wcc_pkg::radial_t                  radial_nxt;
  logic signed [wcc_pkg::PerpW-1:0]  neg [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qa_nxt[i] = $signed({1'b0, axial.q}) * $signed(axis[i]);
      perp_nxt[i] = $signed({{2{d1_r[i][wcc_pkg::DiffW-1]}}, d1_r[i], {wcc_pkg::FracW{1'b0}}})
                  - $signed({{(wcc_pkg::PerpW-wcc_pkg::QaW){qa_r[i][wcc_pkg::QaW-1]}}, qa_r[i]});
      neg[i] = -perp_r[i];
      radial_nxt.mag[i] = perp_r[i][wcc_pkg::PerpW-1] ? neg[i][wcc_pkg::MagW-1:0]
                                                      : perp_r[i][wcc_pkg::MagW-1:0];
    end
    rad1_nxt       = axial.q * tan_half;
    radial_nxt.tag = tag2_r;
    radial_nxt.rad = rad2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r.valid       <= 1'b0;
      tag2_r.valid       <= 1'b0;
      radial_r.tag.valid <= 1'b0;
    end else if (en) begin
      tag1_r.valid       <= axial.tag.valid;
      tag2_r.valid       <= tag1_r.valid;
      radial_r.tag.valid <= radial_nxt.tag.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag1_r.index   <= axial.tag.index;
      tag1_r.inrange <= axial.tag.inrange;
      tag2_r.index   <= tag1_r.index;
      tag2_r.inrange <= tag1_r.inrange;
      for (int i = 0; i < 3; i++) begin
        d1_r[i]   <= $signed(axial.d[i]);
        qa_r[i]   <= qa_nxt[i];
        perp_r[i] <= perp_nxt[i];
      end
      rad1_r <= rad1_nxt;
      rad2_r <= rad1_r;
      radial_r.tag.index   <= radial_nxt.tag.index;
      radial_r.tag.inrange <= radial_nxt.tag.inrange;
      radial_r.mag         <= radial_nxt.mag;
      radial_r.rad         <= radial_nxt.rad;
    end
  end

  assign radial = radial_r;

endmodule

// ===== sv/wcc_square.sv =====
`timescale 1ns / 1ps

module wcc_square (
  input  logic                        clk,
  input  logic                        en,
  input  logic [wcc_pkg::SqInW-1:0]   x,
  output logic [wcc_pkg::SqW-1:0]     sq
);

  logic [wcc_pkg::HalfW-1:0]    hi;
  logic [wcc_pkg::HalfW-1:0]    lo;
  logic [2*wcc_pkg::HalfW-1:0]  hh_r;
  logic [2*wcc_pkg::HalfW-1:0]  hl_r;
  logic [2*wcc_pkg::HalfW-1:0]  ll_r;
  logic [wcc_pkg::SqW-1:0]      sq_r;
  logic [wcc_pkg::SqW-1:0]      sq_nxt;

  // x^2 = hi^2 * 2^2h + 2 * hi * lo * 2^h + lo^2
  always_comb begin
    hi = x[wcc_pkg::SqInW-1:wcc_pkg::HalfW];
    lo = x[wcc_pkg::HalfW-1:0];
    sq_nxt = (wcc_pkg::SqW'(hh_r) << wcc_pkg::SqInW)
           + (wcc_pkg::SqW'(hl_r) << (wcc_pkg::HalfW + 1))
           + wcc_pkg::SqW'(ll_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hh_r <= hi * hi;
      hl_r <= hi * lo;
      ll_r <= lo * lo;
      sq_r <= sq_nxt;
    end
  end

  assign sq = sq_r;

endmodule

// ===== sv/wcc_compare.sv =====
`timescale 1ns / 1ps

module wcc_compare (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  wcc_pkg::tag_t                    tag,
  input  logic [2:0][wcc_pkg::SqW-1:0]     perp_sq,
  input  logic [wcc_pkg::SqW-1:0]          rad_sq,
  output logic                             out_valid,
  output logic [wcc_pkg::IdxW-1:0]         out_index,
  output logic                             out_refine
);

  wcc_pkg::tag_t                  tag_r;
  logic [wcc_pkg::DistW-1:0]      dist_r;
  logic [wcc_pkg::DistW-1:0]      dist_nxt;
  logic [wcc_pkg::SqW-1:0]        rad_r;
  logic                           valid_r;
  logic [wcc_pkg::IdxW-1:0]       index_r;
  logic                           refine_r;
  logic                           refine_nxt;

  always_comb begin
    dist_nxt = wcc_pkg::DistW'(perp_sq[0]) + wcc_pkg::DistW'(perp_sq[1])
             + wcc_pkg::DistW'(perp_sq[2]);
    refine_nxt = tag_r.inrange && (dist_r <= wcc_pkg::DistW'(rad_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r.valid <= 1'b0;
      valid_r     <= 1'b0;
    end else if (en) begin
      tag_r.valid <= tag.valid;
      valid_r     <= tag_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag_r.index   <= tag.index;
      tag_r.inrange <= tag.inrange;
      dist_r        <= dist_nxt;
      rad_r         <= rad_sq;
      index_r       <= tag_r.index;
      refine_r      <= refine_nxt;
    end
  end

  assign out_valid  = valid_r;
  assign out_index  = index_r;
  assign out_refine = refine_r;

endmodule

// ===== sv/wake_cone_cell_classifier.sv =====
`timescale 1ns / 1ps

// Wake cone cell classifier: each word carries one cell centre (Q16.16) and its index and
// returns one word with the same index and a flag that is set when the centre lies inside
// the cone set by the apex, axis, length and half-angle tangent registers (length 0 turns
// refinement off). The pipeline is eleven register stages deep (axial distance, radial
// offset, 28-bit partial-product squarers, final compare) and takes one word per cycle
// while the output is not stalled. A stall on a valid output word holds the whole pipeline,
// with the output register keeping its word. Registers must be written only while no word
// is in flight; the block itself does not enforce this.
module wake_cone_cell_classifier (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [wcc_pkg::IdxW-1:0]        in_cell_index,
  input  logic signed [wcc_pkg::CoordW-1:0] in_cell_x,
  input  logic signed [wcc_pkg::CoordW-1:0] in_cell_y,
  input  logic signed [wcc_pkg::CoordW-1:0] in_cell_z,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [wcc_pkg::IdxW-1:0]        out_result_index,
  output logic                            out_refine_streamwise,
  input  logic                            cfg_we,
  input  logic [wcc_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [wcc_pkg::CfgW-1:0]        cfg_wdata
);

  logic [2:0][wcc_pkg::CoordW-1:0]  origin_r;
  logic [2:0][wcc_pkg::AxisW-1:0]   axis_r;
  logic [wcc_pkg::LenW-1:0]         len_r;
  logic [wcc_pkg::TanW-1:0]         tan_r;

  logic                             en;
  logic [2:0][wcc_pkg::CoordW-1:0]  center;
  wcc_pkg::axial_t                  axial;
  wcc_pkg::radial_t                 radial;
  wcc_pkg::tag_t                    tag1_r;
  wcc_pkg::tag_t                    tag2_r;
  logic [2:0][wcc_pkg::SqW-1:0]     perp_sq;
  logic [wcc_pkg::SqW-1:0]          rad_sq;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_r <= '0;
      axis_r   <= {wcc_pkg::AxisW'(0), wcc_pkg::AxisW'(0), wcc_pkg::AxisW'(65536)};
      len_r    <= '0;
      tan_r    <= '0;
    end else if (cfg_we) begin
      case (wcc_pkg::cfg_reg_t'(cfg_index))
        wcc_pkg::REG_ORIGIN_X:    origin_r[0] <= cfg_wdata;
        wcc_pkg::REG_ORIGIN_Y:    origin_r[1] <= cfg_wdata;
        wcc_pkg::REG_ORIGIN_Z:    origin_r[2] <= cfg_wdata;
        wcc_pkg::REG_AXIS_X:      axis_r[0]   <= cfg_wdata[wcc_pkg::AxisW-1:0];
        wcc_pkg::REG_AXIS_Y:      axis_r[1]   <= cfg_wdata[wcc_pkg::AxisW-1:0];
        wcc_pkg::REG_AXIS_Z:      axis_r[2]   <= cfg_wdata[wcc_pkg::AxisW-1:0];
        wcc_pkg::REG_CONE_LENGTH: len_r       <= cfg_wdata[wcc_pkg::LenW-1:0];
        wcc_pkg::REG_TAN_HALF:    tan_r       <= cfg_wdata[wcc_pkg::TanW-1:0];
        default: ;
      endcase
    end
  end

  // whole pipeline advances unless the output word is held
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;
  assign center   = {in_cell_z, in_cell_y, in_cell_x};

  wcc_axial u_axial (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .in_index (in_cell_index),
    .center   (center),
    .origin   (origin_r),
    .axis     (axis_r),
    .len      (len_r),
    .axial    (axial)
  );

  wcc_radial u_radial (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .axial    (axial),
    .axis     (axis_r),
    .tan_half (tan_r),
    .radial   (radial)
  );

  for (genvar g = 0; g < 3; g++) begin : g_perp_sq
    wcc_square u_sq (
      .clk (clk),
      .en  (en),
      .x   (wcc_pkg::SqInW'(radial.mag[g])),
      .sq  (perp_sq[g])
    );
  end

  wcc_square u_rad_sq (
    .clk (clk),
    .en  (en),
    .x   (wcc_pkg::SqInW'(radial.rad)),
    .sq  (rad_sq)
  );

  // tag follows the two squarer stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r.valid <= 1'b0;
      tag2_r.valid <= 1'b0;
    end else if (en) begin
      tag1_r.valid <= radial.tag.valid;
      tag2_r.valid <= tag1_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag1_r.index   <= radial.tag.index;
      tag1_r.inrange <= radial.tag.inrange;
      tag2_r.index   <= tag1_r.index;
      tag2_r.inrange <= tag1_r.inrange;
    end
  end

  wcc_compare u_compare (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .tag        (tag2_r),
    .perp_sq    (perp_sq),
    .rad_sq     (rad_sq),
    .out_valid  (out_valid),
    .out_index  (out_result_index),
    .out_refine (out_refine_streamwise)
  );

endmodule

// ===== sv/wcc_checker.sv =====
`timescale 1ns / 1ps
`include "wake_cone_cell_classifier_assert.svh"

module wcc_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [wcc_pkg::IdxW-1:0]          out_result_index,
  input logic                              out_refine_streamwise,
  input logic                              cfg_we,
  input logic [wcc_pkg::CfgIdxW-1:0]       cfg_index,
  input logic [wcc_pkg::CfgW-1:0]          cfg_wdata
);

  // tracks whether the cone is switched off
  logic len_zero_r;
  logic len_zero_nxt;

  always_comb begin
    len_zero_nxt = len_zero_r;
    if (cfg_we && (cfg_index == wcc_pkg::REG_CONE_LENGTH)) begin
      len_zero_nxt = (cfg_wdata[wcc_pkg::LenW-1:0] == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_zero_r <= 1'b1;
    end else begin
      len_zero_r <= len_zero_nxt;
    end
  end

  `WCC_ASSERT_NXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(out_result_index) && $stable(out_refine_streamwise),
    "result word changed while stalled")

  `WCC_ASSERT_IMP(a_stall_only_when_full, !out_valid, !in_stall,
    "input stalled with no held result")

  `WCC_ASSERT_IMP(a_stall_follows_out, in_stall, out_stall,
    "input stalled without output stall")

  `WCC_ASSERT_IMP(a_off_no_refine, out_valid && len_zero_r, !out_refine_streamwise,
    "refine flagged with cone length zero")

endmodule

bind wake_cone_cell_classifier wcc_checker u_wcc_checker (.*);

// ===== verif/wake_cone_cell_classifier_test.sv =====
`timescale 1ns / 1ps

module wake_cone_cell_classifier_test;

  localparam int ONE = 65536;
  localparam logic [31:0] MAXC = 32'h7fff_ffff;
  localparam logic [31:0] MINC = 32'h8000_0000;

  typedef struct packed {
    logic [2:0][31:0] origin;
    logic [2:0][17:0] axis;
    logic [30:0]      len;
    logic [23:0]      tanv;
  } cone_cfg_t;

  typedef struct packed {
    logic [23:0]      idx;
    logic [2:0][31:0] pos;
  } cell_t;

  typedef struct packed {
    logic [23:0] idx;
    logic        refine;
  } cone_result_t;

  typedef enum int {
    CONE_RESET,
    CONE_UNIT45,
    CONE_NEEDLE_X,
    CONE_WIDEST,
    CONE_SKEWED
  } dir_cone_t;

  typedef enum int {
    KIND_TYPICAL,
    KIND_EXTREME,
    KIND_OFF,
    KIND_NEEDLE
  } cone_kind_t;

  typedef struct {
    dir_cone_t   setting;
    logic [23:0] idx;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    bit          typed;
    bit          refine;
  } cone_row_t;

  logic                               clk;
  logic                               rst_n;
  logic                               in_valid;
  logic                               in_stall;
  logic [wcc_pkg::IdxW-1:0]           in_cell_index;
  logic signed [wcc_pkg::CoordW-1:0]  in_cell_x;
  logic signed [wcc_pkg::CoordW-1:0]  in_cell_y;
  logic signed [wcc_pkg::CoordW-1:0]  in_cell_z;
  logic                               out_valid;
  logic                               out_stall;
  logic [wcc_pkg::IdxW-1:0]           out_result_index;
  logic                               out_refine_streamwise;
  logic                               cfg_we;
  wcc_pkg::cfg_reg_t                  cfg_index;
  logic [wcc_pkg::CfgW-1:0]           cfg_wdata;

  cone_cfg_t    cur_cone;
  cone_cfg_t    dir_cones [5];
  cone_result_t refine_due_q [$];
  int           refine_errors = 0;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  bit           long_hold_pending = 1'b0;

  // directed cells: block-off extremes, edges of 45 deg, needle, wide and skewed cones
  cone_row_t cone_rows [22] = '{
    '{CONE_RESET,    24'h000000, 0,              0,              0,         1'b1, 1'b0},
    '{CONE_RESET,    24'hffffff, MAXC,           MINC,           MAXC,      1'b1, 1'b0},
    '{CONE_RESET,    24'h5a5a5a, MINC,           MAXC,           MINC,      1'b1, 1'b0},
    '{CONE_RESET,    24'ha5a5a5, 10 * ONE,       0,              0,         1'b1, 1'b0},
    '{CONE_UNIT45,   24'h000002, 10 * ONE,       0,              0,         1'b1, 1'b1},
    '{CONE_UNIT45,   24'h000003, 10 * ONE,       10 * ONE,       0,         1'b1, 1'b1},
    '{CONE_UNIT45,   24'h000004, 10 * ONE,       10 * ONE + 1,   0,         1'b1, 1'b0},
    '{CONE_UNIT45,   24'h000005, 10 * ONE,       0,              -10 * ONE, 1'b1, 1'b1},
    '{CONE_UNIT45,   24'h000006, 0,              0,              0,         1'b1, 1'b0},
    '{CONE_UNIT45,   24'h000007, -10 * ONE,      0,              0,         1'b1, 1'b0},
    '{CONE_UNIT45,   24'h000008, 100 * ONE,      0,              0,         1'b1, 1'b1},
    '{CONE_UNIT45,   24'h000009, 100 * ONE + 1,  0,              0,         1'b1, 1'b0},
    '{CONE_UNIT45,   24'h00000a, 50 * ONE,       30 * ONE,       -40 * ONE, 1'b1, 1'b1},
    '{CONE_NEEDLE_X, 24'h00000b, 10 * ONE,       0,              0,         1'b1, 1'b1},
    '{CONE_NEEDLE_X, 24'h00000c, 10 * ONE,       0,              1,         1'b1, 1'b0},
    '{CONE_WIDEST,   24'h00000d, MAXC,           MINC,           MAXC,      1'b0, 1'b0},
    '{CONE_WIDEST,   24'h00000e, MINC,           MAXC,           MINC,      1'b0, 1'b0},
    '{CONE_WIDEST,   24'h00000f, 0,              0,              0,         1'b0, 1'b0},
    '{CONE_WIDEST,   24'h000010, MAXC,           MAXC,           MINC,      1'b0, 1'b0},
    '{CONE_SKEWED,   24'h000011, 12 * ONE,       3 * ONE,        -2 * ONE,  1'b0, 1'b0},
    '{CONE_SKEWED,   24'h000012, 20 * ONE,       20 * ONE,       20 * ONE,  1'b0, 1'b0},
    '{CONE_SKEWED,   24'h000013, 7 * ONE,        0,              0,         1'b0, 1'b0}
  };

  cone_kind_t phase_kind [8] = '{KIND_TYPICAL, KIND_TYPICAL, KIND_NEEDLE, KIND_EXTREME,
                                 KIND_TYPICAL, KIND_OFF, KIND_TYPICAL, KIND_EXTREME};

  wake_cone_cell_classifier u_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_cell_index         (in_cell_index),
    .in_cell_x             (in_cell_x),
    .in_cell_y             (in_cell_y),
    .in_cell_z             (in_cell_z),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_result_index      (out_result_index),
    .out_refine_streamwise (out_refine_streamwise),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata)
  );

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic cone_cfg_t make_cone(input logic [31:0] ox, input logic [31:0] oy,
                                          input logic [31:0] oz, input logic [17:0] ax,
                                          input logic [17:0] ay, input logic [17:0] az,
                                          input logic [30:0] len, input logic [23:0] tanv);
    cone_cfg_t c;
    c.origin[0] = ox;
    c.origin[1] = oy;
    c.origin[2] = oz;
    c.axis[0] = ax;
    c.axis[1] = ay;
    c.axis[2] = az;
    c.len = len;
    c.tanv = tanv;
    return c;
  endfunction

  // exact test on squares: 0 < p <= len and |perp|^2 <= (q * tan)^2
  function automatic bit cone_refines(input cell_t pt);
    longint      d [3];
    longint      a [3];
    longint      p;
    longint      q;
    longint      perp;
    logic [63:0] mag;
    logic [63:0] radius;
    logic [127:0] sum_sq;
    logic [127:0] rad_sq;
    p = 0;
    sum_sq = '0;
    for (int i = 0; i < 3; i++) begin
      d[i] = longint'($signed(pt.pos[i])) - longint'($signed(cur_cone.origin[i]));
      a[i] = longint'($signed(cur_cone.axis[i]));
      p += d[i] * a[i];
    end
    if (p <= 0 || p > (longint'(cur_cone.len) <<< 16)) return 1'b0;
    q = p >>> 16;
    for (int i = 0; i < 3; i++) begin
      perp = d[i] * 65536 - q * a[i];
      mag = (perp < 0) ? -perp : perp;
      sum_sq += {64'd0, mag} * {64'd0, mag};
    end
    radius = 64'(q) * 64'(cur_cone.tanv);
    rad_sq = {64'd0, radius} * {64'd0, radius};
    return sum_sq <= rad_sq;
  endfunction

  function automatic cone_cfg_t random_cone(input cone_kind_t kind);
    cone_cfg_t   c;
    int unsigned pick;
    for (int i = 0; i < 3; i++) begin
      if (kind == KIND_EXTREME) c.origin[i] = $urandom;
      else c.origin[i] = $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
    end
    pick = (kind == KIND_EXTREME) ? 5 : $urandom_range(0, 5);
    case (pick)
      0: c.axis = {18'd0, 18'd0, 18'(ONE)};
      1: c.axis = {18'd0, 18'(ONE), 18'd0};
      2: c.axis = {18'(-ONE), 18'd0, 18'd0};
      3: c.axis = {18'd0, 18'd52429, 18'd39322};
      4: c.axis = {18'd37837, 18'd37837, 18'(-37837)};
      default: begin
        for (int i = 0; i < 3; i++) c.axis[i] = 18'($urandom);
      end
    endcase
    if (kind == KIND_EXTREME) begin
      c.len = ($urandom_range(0, 1) != 0) ? 31'h7fff_ffff : 31'($urandom);
      c.tanv = ($urandom_range(0, 1) != 0) ? 24'hff_ffff : 24'($urandom);
    end else begin
      c.len = (kind == KIND_OFF) ? 31'd0 : 31'($urandom_range(ONE, 32'h0400_0000));
      c.tanv = (kind == KIND_NEEDLE) ? 24'd0 : 24'($urandom_range(0, 2 * ONE));
    end
    return c;
  endfunction

  // mostly cells around the cone body near its surface, some anywhere
  function automatic cell_t random_cell();
    cell_t  c;
    longint lenq;
    longint t;
    longint w;
    longint base;
    c.idx = 24'($urandom);
    if ($urandom_range(0, 99) < 15) begin
      for (int i = 0; i < 3; i++) c.pos[i] = $urandom;
    end else begin
      lenq = longint'(cur_cone.len);
      t = longint'(rand64() % 64'(lenq + lenq / 4 + 2)) - lenq / 8 - 1;
      w = (t * longint'(cur_cone.tanv)) >>> 16;
      if (w < 0) w = -w;
      w = w + w / 8 + 2;
      for (int i = 0; i < 3; i++) begin
        base = longint'($signed(cur_cone.origin[i]))
             + ((t * longint'($signed(cur_cone.axis[i]))) >>> 16)
             + longint'(rand64() % 64'(2 * w + 1)) - w;
        c.pos[i] = 32'(base);
      end
    end
    return c;
  endfunction

  task automatic write_reg(input wcc_pkg::cfg_reg_t which, input logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= which;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // unused upper bits of the narrow registers carry noise
  task automatic load_cone(input cone_cfg_t c);
    write_reg(wcc_pkg::REG_ORIGIN_X, c.origin[0]);
    write_reg(wcc_pkg::REG_ORIGIN_Y, c.origin[1]);
    write_reg(wcc_pkg::REG_ORIGIN_Z, c.origin[2]);
    write_reg(wcc_pkg::REG_AXIS_X, {14'($urandom), c.axis[0]});
    write_reg(wcc_pkg::REG_AXIS_Y, {14'($urandom), c.axis[1]});
    write_reg(wcc_pkg::REG_AXIS_Z, {14'($urandom), c.axis[2]});
    write_reg(wcc_pkg::REG_CONE_LENGTH, {1'($urandom), c.len});
    write_reg(wcc_pkg::REG_TAN_HALF, {8'($urandom), c.tanv});
    cfg_we <= 1'b0;
    cur_cone = c;
  endtask

  task automatic send_cell(input cell_t pt, input bit typed, input bit typed_refine);
    cone_result_t want;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cell_index <= pt.idx;
    in_cell_x <= pt.pos[0];
    in_cell_y <= pt.pos[1];
    in_cell_z <= pt.pos[2];
    want.idx = pt.idx;
    want.refine = typed ? typed_refine : cone_refines(pt);
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    refine_due_q.push_back(want);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (refine_due_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : recv_side
    int hold_left;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_pending) begin
        long_hold_pending = 1'b0;
        hold_left = 120;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin : result_check
    cone_result_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (refine_due_q.size() == 0) begin
        refine_errors++;
        if (refine_errors <= 10)
          $display("unexpected word: index %h refine %b", out_result_index,
                   out_refine_streamwise);
      end else begin
        want = refine_due_q.pop_front();
        if (out_result_index !== want.idx || out_refine_streamwise !== want.refine) begin
          refine_errors++;
          if (refine_errors <= 10)
            $display("mismatch: expected index %h refine %b, got index %h refine %b",
                     want.idx, want.refine, out_result_index, out_refine_streamwise);
        end
      end
    end
  end

  initial begin : stimulus
    cell_t     pt;
    dir_cone_t dir_now;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_cell_index <= '0;
    in_cell_x <= '0;
    in_cell_y <= '0;
    in_cell_z <= '0;
    cfg_we <= 1'b0;
    cfg_index <= wcc_pkg::REG_ORIGIN_X;
    cfg_wdata <= '0;
    dir_cones[CONE_RESET] = make_cone(0, 0, 0, 18'(ONE), 18'd0, 18'd0, 31'd0, 24'd0);
    dir_cones[CONE_UNIT45] = make_cone(0, 0, 0, 18'(ONE), 18'd0, 18'd0, 31'(100 * ONE),
                                       24'(ONE));
    dir_cones[CONE_NEEDLE_X] = make_cone(0, 0, 0, 18'(ONE), 18'd0, 18'd0, 31'(100 * ONE),
                                         24'd0);
    dir_cones[CONE_WIDEST] = make_cone(MINC, MAXC, MINC, 18'h20000, 18'h1ffff, 18'h20000,
                                       31'h7fff_ffff, 24'hff_ffff);
    dir_cones[CONE_SKEWED] = make_cone(5 * ONE, -3 * ONE, ONE, 18'd98304, 18'd32768,
                                       18'(-16384), 31'(40 * ONE), 24'h8000);
    cur_cone = dir_cones[CONE_RESET];
    dir_now = CONE_RESET;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < 22; r++) begin
      if (cone_rows[r].setting != dir_now) begin
        drain_results();
        dir_now = cone_rows[r].setting;
        load_cone(dir_cones[dir_now]);
      end
      pt.idx = cone_rows[r].idx;
      pt.pos[0] = cone_rows[r].x;
      pt.pos[1] = cone_rows[r].y;
      pt.pos[2] = cone_rows[r].z;
      send_cell(pt, cone_rows[r].typed, cone_rows[r].refine);
    end

    for (int ph = 0; ph < 8; ph++) begin
      drain_results();
      send_idle_pct = (ph % 4 == 1) ? 84 : (ph % 4 == 3) ? 25 : 0;
      recv_stall_pct = (ph % 4 == 2) ? 84 : (ph % 4 == 3) ? 25 : 0;
      load_cone(random_cone(phase_kind[ph]));
      if (ph == 0) begin
        // output held off while words keep coming, so the pipeline backs up
        long_hold_pending = 1'b1;
        repeat (40) send_cell(random_cell(), 1'b0, 1'b0);
        drain_results();
      end
      repeat (212) send_cell(random_cell(), 1'b0, 1'b0);
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (refine_errors == 0 && refine_due_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
